// File: src/cse_pkg.sv
package cse_pkg;

	localparam int MAX_KNOTS_DEF = 256;
	localparam int FRAC_BITS_DEF = 16;
	localparam int KNOT_CNT_W = 9;
	localparam int SEG_W = 8;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_EVAL = 1'b1;

	typedef struct packed {
		logic               kind;
		logic [7:0]         entry_index;
		logic signed [31:0] knot_x;
		logic signed [31:0] knot_y;
		logic signed [31:0] coef_linear;
		logic signed [31:0] coef_quadratic;
		logic signed [31:0] coef_cubic;
		logic signed [31:0] query_u;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic signed [31:0] slope;
		logic signed [31:0] curvature;
		logic [7:0]         segment;
	} out_item_t;

	function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'sd2147483647) r = 32'sh7fffffff;
		else if (v < -34'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

endpackage

// File: src/cubic_spline_eval_with_derivatives_top.sv
// Cubic spline evaluator with slope and curvature, signed fixed point.
// The input channel (in_valid/in_ready/in_data) carries load and evaluate
// transfers. A load writes one knot entry at its transfer and gives no result,
// so loads may follow each other every cycle while no evaluate is in work.
// An evaluate transfer gives one result on the output channel
// (out_valid/out_ready/out_data) with value, slope, curvature and segment.
// An evaluate first reads and checks the remembered segment, then, when that
// check fails, runs a binary search (about log2 of the knot count steps, eight
// for 256 knots), then fetches the entry, runs four registered multiplies and
// loads the output register, which raises out_valid. The registered read of the
// table memory sets the search time, the multiplier chain the rest.
// One item is in work at a time; the input is ready again in the cycle after
// the result is moved into the output register. A new item may start while
// the previous result waits for the receiver; its own result then waits in
// the block, and the input stalls until the output is free.
// A stalled receiver holds the result unchanged.
// Reset clears the control state, the remembered segment and sets the knot
// count to 2; the knot table itself is undefined until loaded.
module cubic_spline_eval_with_derivatives_top #(
	parameter int MAX_KNOTS = cse_pkg::MAX_KNOTS_DEF,
	parameter int FRAC_BITS = cse_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [cse_pkg::KNOT_CNT_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  cse_pkg::in_item_t                   in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output cse_pkg::out_item_t                  out_data
);

	localparam int AW = $clog2(MAX_KNOTS);
	localparam int TOP = (MAX_KNOTS < 256) ? MAX_KNOTS : 256;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CHK0, ST_CHK1, ST_CHK2, ST_CHK3, ST_SRCH, ST_SRCHW, ST_FETCH,
		ST_FETCHW, ST_M1, ST_M2, ST_M3, ST_DONE
	} state_t;

	logic [31:0] mem_x [MAX_KNOTS];
	logic [127:0] mem_c [MAX_KNOTS];

	state_t state_q;
	logic [cse_pkg::KNOT_CNT_W-1:0] knot_count_q;
	logic [8:0] n_q, lo_q, hi_q, mid_q;
	logic [cse_pkg::SEG_W-1:0] last_seg_q;
	logic signed [31:0] u_q, dx_q, xlo_q;
	logic signed [31:0] y_q, b_q, c_q, d_q, e_q, t_q, g_q;
	logic [AW-1:0] raddr;
	logic [31:0] rx_q;
	logic [127:0] rc_q;
	logic wr_en;
	logic [1:0] mcnt_q;
	logic signed [31:0] ma, mb, mp;
	logic out_valid_q;
	cse_pkg::out_item_t out_q;
	cse_pkg::out_item_t res_q;

	cse_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign wr_en = in_valid && in_ready && (in_data.kind == cse_pkg::KIND_LOAD) &&
		({1'b0, in_data.entry_index} < 9'(TOP));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_x[AW'(in_data.entry_index)] <= in_data.knot_x;
			mem_c[AW'(in_data.entry_index)] <= {in_data.knot_y, in_data.coef_linear,
				in_data.coef_quadratic, in_data.coef_cubic};
		end
		rx_q <= mem_x[raddr];
		rc_q <= mem_c[raddr];
	end

	logic [8:0] mid_c;
	logic [8:0] seg_c;
	logic signed [31:0] c2, e3, e6, sum_a;
	always_comb begin
		mid_c = 9'((10'(lo_q) + 10'(hi_q)) >> 1);
		seg_c = ({1'b0, last_seg_q} >= n_q - 9'd1) ? 9'd0 : {1'b0, last_seg_q};
		raddr = AW'(lo_q);
		unique case (state_q)
			ST_CHK2: raddr = AW'(lo_q + 9'd1);
			ST_SRCH: raddr = AW'(mid_c);
			default: raddr = AW'(lo_q);
		endcase
		c2 = cse_pkg::sat34(34'(c_q) <<< 1);
		e3 = cse_pkg::sat34(34'(e_q) * 34'sd3);
		e6 = cse_pkg::sat34(34'(e3) <<< 1);
		sum_a = cse_pkg::sat34(34'(c2) + 34'(e3));
		ma = dx_q;
		unique case (state_q)
			ST_M1: mb = d_q;
			ST_M2: mb = (mcnt_q == 2'd0) ? cse_pkg::sat34(34'(c_q) + 34'(e_q)) : sum_a;
			ST_M3: mb = t_q;
			default: mb = d_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			knot_count_q <= 9'd2;
			last_seg_q <= '0;
			out_valid_q <= 1'b0;
			mcnt_q <= '0;
		end else begin
			if (cfg_we) knot_count_q <= cfg_data;
			if (state_q == ST_DONE && (!out_valid_q || out_ready)) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready && in_data.kind == cse_pkg::KIND_EVAL) begin
						u_q <= in_data.query_u;
						n_q <= (knot_count_q < 9'd2) ? 9'd2 :
							(knot_count_q > 9'(TOP)) ? 9'(TOP) : knot_count_q;
						state_q <= ST_CHK0;
					end
				end
				ST_CHK0: begin
					lo_q <= seg_c;
					state_q <= ST_CHK1;
				end
				ST_CHK1: begin
					// Address lo now; rx_q holds x(lo) next cycle.
					state_q <= ST_CHK2;
				end
				ST_CHK2: begin
					xlo_q <= rx_q;
					state_q <= ST_CHK3;
				end
				ST_CHK3: begin
					if (u_q < xlo_q || u_q > $signed(rx_q)) begin
						lo_q <= 9'd0;
						hi_q <= n_q;
						state_q <= ST_SRCH;
					end else begin
						state_q <= ST_FETCH;
					end
				end
				ST_SRCHW: begin
					if (u_q < $signed(rx_q)) hi_q <= mid_q; else lo_q <= mid_q;
					if ((u_q < $signed(rx_q) ? mid_q : hi_q) > (u_q < $signed(rx_q)
						? lo_q : mid_q) + 9'd1) state_q <= ST_SRCH;
					else state_q <= ST_FETCH;
				end
				ST_SRCH: begin
					mid_q <= mid_c;
					state_q <= ST_SRCHW;
				end
				ST_FETCH: state_q <= ST_FETCHW;
				ST_FETCHW: begin
					last_seg_q <= lo_q[7:0];
					xlo_q <= rx_q;
					{y_q, b_q, c_q, d_q} <= rc_q;
					dx_q <= cse_pkg::sat34(34'(u_q) - 34'($signed(rx_q)));
					mcnt_q <= '0;
					state_q <= ST_M1;
				end
				ST_M1: begin
					if (mcnt_q == 2'd1) begin
						e_q <= mp;
						mcnt_q <= '0;
						state_q <= ST_M2;
					end else begin
						mcnt_q <= mcnt_q + 2'd1;
					end
				end
				ST_M2: begin
					if (mcnt_q == 2'd2) begin
						g_q <= cse_pkg::sat34(34'(b_q) + 34'(mp));
						mcnt_q <= '0;
						state_q <= ST_M3;
					end else begin
						if (mcnt_q == 2'd1) t_q <= cse_pkg::sat34(34'(b_q) + 34'(mp));
						mcnt_q <= mcnt_q + 2'd1;
					end
				end
				ST_M3: begin
					if (mcnt_q == 2'd1) begin
						res_q.value <= cse_pkg::sat34(34'(y_q) + 34'(mp));
						res_q.slope <= g_q;
						res_q.curvature <= cse_pkg::sat34(34'(c2) + 34'(e6));
						res_q.segment <= lo_q[7:0];
						mcnt_q <= '0;
						state_q <= ST_DONE;
					end else begin
						mcnt_q <= mcnt_q + 2'd1;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_q <= res_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: src/cse_qmul.sv
module cse_qmul #(
	parameter int FRAC_BITS = cse_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic signed [31:0] p
);

	logic signed [63:0] prod_q;
	logic signed [63:0] shifted;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	always_comb begin
		shifted = prod_q >>> FRAC_BITS;
		if (shifted > 64'sd2147483647) p = 32'sh7fffffff;
		else if (shifted < -64'sd2147483648) p = 32'sh80000000;
		else p = shifted[31:0];
	end

endmodule
